// File: design/assert_macros.svh
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define TWE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, quiet while reset is asserted.
`define TWE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: design/twe_pkg.sv
`timescale 1ns / 1ps
package twe_pkg;

	localparam int WHEEL_SLOTS = 16;
	localparam int SLOT_DEPTH  = 64;
	localparam int CONNS       = 1024;

	// fixed field widths
	localparam int OP_W       = 1;
	localparam int CONN_ID_W  = 10;
	localparam int DELAY_W    = 4;
	localparam int OFFSET_W   = 4;
	localparam int KIND_W     = 2;
	localparam int COUNT_W    = 11;

	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd10;
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = 11'd2047;

	// derived sizes; slot and connection counts are powers of two
	localparam int SLOT_W  = $clog2(WHEEL_SLOTS);
	localparam int ENT_W   = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
	localparam int FILL_W  = $clog2(SLOT_DEPTH + 1);
	localparam int CID_W   = $clog2(CONNS);
	localparam int EADDR_W = SLOT_W + ENT_W;
	localparam int SUM_W   = SLOT_W + 5;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD     = 2'd0,
		KIND_EXPIRED = 2'd1,
		KIND_EMPTY   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [CONN_ID_W-1:0] conn_id;
		logic [COUNT_W-1:0]   remaining;
		logic                 killed;
		logic                 overflow;
		logic                 last;
	} result_t;

	// reference-count memory access
	typedef struct packed {
		logic               we;
		logic [CID_W-1:0]   waddr;
		logic [COUNT_W-1:0] wdata;
		logic               re;
		logic [CID_W-1:0]   raddr;
	} ref_port_t;

	// slot entry memory access
	typedef struct packed {
		logic               we;
		logic [EADDR_W-1:0] waddr;
		logic [CID_W-1:0]   wdata;
		logic               re;
		logic [EADDR_W-1:0] raddr;
	} ent_port_t;

endpackage

// File: design/twe_in_if.sv
`timescale 1ns / 1ps
interface twe_in_if;
	import twe_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [CONN_ID_W-1:0] conn_id;
	logic [DELAY_W-1:0]   delay;

	modport source(output valid, op, conn_id, delay, input ready);
	modport sink(input valid, op, conn_id, delay, output ready);
endinterface

// File: design/twe_out_if.sv
`timescale 1ns / 1ps
interface twe_out_if;
	import twe_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [CONN_ID_W-1:0] conn_id_out;
	logic [COUNT_W-1:0]   remaining;
	logic                 killed;
	logic                 overflow;
	logic                 last;

	modport source(output valid, kind, conn_id_out, remaining, killed, overflow, last,
		input ready);
	modport sink(input valid, kind, conn_id_out, remaining, killed, overflow, last,
		output ready);
endinterface

// File: design/twe_ram.sv
`timescale 1ns / 1ps
module twe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: design/twe_seq.sv
`timescale 1ns / 1ps
module twe_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	twe_in_if.sink                        item,
	input  logic [twe_pkg::OFFSET_W-1:0]  offset,
	input  logic                          out_free,
	output logic                          res_load,
	output twe_pkg::result_t              res,
	output twe_pkg::ref_port_t            ref_port,
	input  logic [twe_pkg::COUNT_W-1:0]   ref_rdata,
	output twe_pkg::ent_port_t            ent_port,
	input  logic [twe_pkg::CID_W-1:0]     ent_rdata
);
	import twe_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_ADD   = 6'b000100,
		S_EMPTY = 6'b001000,
		S_TREF  = 6'b010000,
		S_TDONE = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	logic [CID_W-1:0]    clr_q;
	logic [SLOT_W-1:0]   pos_q;
	logic [FILL_W-1:0]   fill_q [WHEEL_SLOTS];
	logic [SLOT_W-1:0]   slot_q;
	logic [CID_W-1:0]    conn_q;
	logic [CID_W-1:0]    tconn_q;
	logic [FILL_W-1:0]   idx_q;
	logic [FILL_W-1:0]   cnt_q;

	logic                accept;
	logic [SUM_W-1:0]    slot_sum;
	logic [SLOT_W-1:0]   add_slot;
	logic [SLOT_W-1:0]   fill_ridx;
	logic [FILL_W-1:0]   fill_rd;
	logic                full;
	logic [COUNT_W-1:0]  inc_cnt;
	logic [COUNT_W-1:0]  dec_cnt;
	logic [FILL_W-1:0]   idx_nxt;
	logic                ent_last;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;

	assign slot_sum = SUM_W'(pos_q) + SUM_W'(offset) + SUM_W'(item.delay);
	assign add_slot = slot_sum[SLOT_W-1:0];

	// one read port on the fill counters
	assign fill_ridx = (state_q == S_IDLE) ? pos_q : slot_q;
	assign fill_rd   = fill_q[fill_ridx];
	assign full      = (fill_rd == FILL_W'(SLOT_DEPTH));

	assign inc_cnt  = (ref_rdata == COUNT_MAX) ? ref_rdata : ref_rdata + COUNT_W'(1);
	assign dec_cnt  = (ref_rdata == '0) ? ref_rdata : ref_rdata - COUNT_W'(1);
	assign idx_nxt  = idx_q + FILL_W'(1);
	assign ent_last = (idx_nxt == cnt_q);

	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		res      = '{kind: KIND_ADD, default: '0};
		ref_port = '0;
		ent_port = '0;
		case (state_q)
			S_CLEAR: begin
				ref_port.we    = 1'b1;
				ref_port.waddr = clr_q;
				if (clr_q == CID_W'(CONNS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (item.op == OP_ADD) begin
						ref_port.re    = 1'b1;
						ref_port.raddr = item.conn_id[CID_W-1:0];
						state_d        = S_ADD;
					end else if (fill_rd == '0) begin
						state_d = S_EMPTY;
					end else begin
						ent_port.re    = 1'b1;
						ent_port.raddr = {pos_q, ENT_W'(0)};
						state_d        = S_TREF;
					end
				end
			end
			S_ADD: begin
				if (out_free) begin
					res_load      = 1'b1;
					res.kind      = KIND_ADD;
					res.conn_id   = CONN_ID_W'(conn_q);
					res.remaining = full ? ref_rdata : inc_cnt;
					res.overflow  = full;
					res.last      = 1'b1;
					if (!full) begin
						ent_port.we    = 1'b1;
						ent_port.waddr = {slot_q, fill_rd[ENT_W-1:0]};
						ent_port.wdata = conn_q;
						ref_port.we    = 1'b1;
						ref_port.waddr = conn_q;
						ref_port.wdata = inc_cnt;
					end
					state_d = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (out_free) begin
					res_load = 1'b1;
					res.kind = KIND_EMPTY;
					res.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_TREF: begin
				// count read for this entry, entry read for the next one
				ref_port.re    = 1'b1;
				ref_port.raddr = ent_rdata;
				if (!ent_last) begin
					ent_port.re    = 1'b1;
					ent_port.raddr = {slot_q, idx_nxt[ENT_W-1:0]};
				end
				state_d = S_TDONE;
			end
			S_TDONE: begin
				if (out_free) begin
					res_load       = 1'b1;
					res.kind       = KIND_EXPIRED;
					res.conn_id    = CONN_ID_W'(tconn_q);
					res.remaining  = dec_cnt;
					res.killed     = (dec_cnt == '0);
					res.last       = ent_last;
					ref_port.we    = 1'b1;
					ref_port.waddr = tconn_q;
					ref_port.wdata = dec_cnt;
					state_d        = ent_last ? S_IDLE : S_TREF;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pos_q   <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < WHEEL_SLOTS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + CID_W'(1);
			end
			if (accept && item.op == OP_TICK) begin
				pos_q          <= pos_q + SLOT_W'(1);
				cnt_q          <= fill_rd;
				idx_q          <= '0;
				fill_q[pos_q]  <= '0;
			end
			if (state_q == S_ADD && out_free && !full) begin
				fill_q[slot_q] <= fill_rd + FILL_W'(1);
			end
			if (state_q == S_TDONE && out_free) begin
				idx_q <= idx_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= (item.op == OP_ADD) ? add_slot : pos_q;
			conn_q <= item.conn_id[CID_W-1:0];
		end
		if (state_q == S_TREF) begin
			tconn_q <= ent_rdata;
		end
	end
endmodule

// File: design/timing_wheel_conn_expiry.sv
// Single-level timing wheel of 16 slots, up to 64 entries per slot, that expires
// connection references. An add (op 0) files conn_id into slot
// (position + expire_offset + delay) mod 16, bumps that connection's count and
// returns one acknowledge (overflow set and nothing changed when the slot is full).
// A tick (op 1) drains the slot at the current position in insertion order,
// returning one result per entry with the decremented count and a killed flag,
// or a single empty-slot result, and advances the position. Results flagged last
// close each request. An add passes through S_ADD; a tick drains each entry through
// S_TREF then S_TDONE, set by the reference-count read/write turnaround on its
// single-port-pair RAM. After reset the block clears the 1024-entry count RAM,
// holding item.ready low until done. Each cfg_we write is taken; the user must
// make them only while no request is in flight, which the block does not enforce.
`timescale 1ns / 1ps
module timing_wheel_conn_expiry (
	input  logic                         clk,
	input  logic                         arst_n,
	twe_in_if.sink                       item,
	twe_out_if.source                    result,
	input  logic                         cfg_we,
	input  logic [twe_pkg::OFFSET_W-1:0] cfg_wdata
);
	import twe_pkg::*;

	logic [OFFSET_W-1:0] offset_q;
	result_t             res_q;
	logic                res_valid_q;
	logic                out_free;
	logic                res_load;
	result_t             res;
	ref_port_t           ref_port;
	ent_port_t           ent_port;
	logic [COUNT_W-1:0]  ref_rdata;
	logic [CID_W-1:0]    ent_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	assign out_free = !res_valid_q || result.ready;

	twe_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.offset    (offset_q),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res),
		.ref_port  (ref_port),
		.ref_rdata (ref_rdata),
		.ent_port  (ent_port),
		.ent_rdata (ent_rdata)
	);

	twe_ram #(.WIDTH(COUNT_W), .DEPTH(CONNS)) u_ref_ram (
		.clk   (clk),
		.we    (ref_port.we),
		.waddr (ref_port.waddr),
		.wdata (ref_port.wdata),
		.re    (ref_port.re),
		.raddr (ref_port.raddr),
		.rdata (ref_rdata)
	);

	twe_ram #(.WIDTH(CID_W), .DEPTH(WHEEL_SLOTS * SLOT_DEPTH)) u_ent_ram (
		.clk   (clk),
		.we    (ent_port.we),
		.waddr (ent_port.waddr),
		.wdata (ent_port.wdata),
		.re    (ent_port.re),
		.raddr (ent_port.raddr),
		.rdata (ent_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.kind        = res_q.kind;
	assign result.conn_id_out = res_q.conn_id;
	assign result.remaining   = res_q.remaining;
	assign result.killed      = res_q.killed;
	assign result.overflow    = res_q.overflow;
	assign result.last        = res_q.last;
endmodule

// File: design/twe_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module twe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [twe_pkg::KIND_W-1:0]    out_kind,
	input logic [twe_pkg::CONN_ID_W-1:0] out_conn_id,
	input logic [twe_pkg::COUNT_W-1:0]   out_remaining,
	input logic                          out_killed,
	input logic                          out_overflow,
	input logic                          out_last
);
	import twe_pkg::*;

	`TWE_ASSERT_NEXT(a_result_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_conn_id) && $stable(out_remaining) && $stable(out_last))
	// a tick still draining never lets a new request in
	`TWE_ASSERT_IMP(a_no_accept_mid_drain, clk, arst_n, out_valid && !out_last, !in_ready)
	`TWE_ASSERT_IMP(a_single_result, clk, arst_n, out_valid && (out_kind == KIND_ADD || out_kind == KIND_EMPTY), out_last)
	`TWE_ASSERT_IMP(a_killed_consistent, clk, arst_n, out_valid && out_killed, out_kind == KIND_EXPIRED && out_remaining == '0 && !out_overflow)
endmodule

bind timing_wheel_conn_expiry twe_checker u_twe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (item.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_kind      (result.kind),
	.out_conn_id   (result.conn_id_out),
	.out_remaining (result.remaining),
	.out_killed    (result.killed),
	.out_overflow  (result.overflow),
	.out_last      (result.last)
);

// File: tb/timing_wheel_conn_expiry_tb.sv
`timescale 1ns / 1ps
module timing_wheel_conn_expiry_tb;
	import twe_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [OFFSET_W-1:0] cfg_wdata;

	twe_in_if  item_if();
	twe_out_if result_if();

	timing_wheel_conn_expiry u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow copy of the wheel
	logic [COUNT_W-1:0]   conn_refs  [CONNS];
	logic [CONN_ID_W-1:0] slot_conns [WHEEL_SLOTS][SLOT_DEPTH];
	int unsigned          slot_used  [WHEEL_SLOTS];
	logic [SLOT_W-1:0]    wheel_pos;
	logic [OFFSET_W-1:0]  expire_off;
	result_t              expected_results [$];

	int src_idle_pct;
	int snk_stall_pct;
	int fail_cnt;
	int n_adds, n_ticks, n_results, n_overflows, n_kills;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void push_expected(kind_t k, logic [CONN_ID_W-1:0] c,
			logic [COUNT_W-1:0] rem, logic kl, logic ov, logic la);
		result_t e;
		e.kind      = k;
		e.conn_id   = c;
		e.remaining = rem;
		e.killed    = kl;
		e.overflow  = ov;
		e.last      = la;
		expected_results.push_back(e);
	endfunction

	function automatic void predict_request(logic op, logic [CONN_ID_W-1:0] conn,
			logic [DELAY_W-1:0] dly);
		logic [SLOT_W-1:0]    slot;
		logic [CONN_ID_W-1:0] c;
		int unsigned          used;
		int unsigned          i;
		if (op == OP_ADD) begin
			n_adds++;
			slot = wheel_pos + expire_off + dly;
			used = slot_used[slot];
			if (used >= SLOT_DEPTH) begin
				n_overflows++;
				push_expected(KIND_ADD, conn, conn_refs[conn], 1'b0, 1'b1, 1'b1);
			end else begin
				slot_conns[slot][used] = conn;
				slot_used[slot] = used + 1;
				if (conn_refs[conn] < COUNT_MAX)
					conn_refs[conn] = conn_refs[conn] + 1'b1;
				push_expected(KIND_ADD, conn, conn_refs[conn], 1'b0, 1'b0, 1'b1);
			end
		end else begin
			n_ticks++;
			slot = wheel_pos;
			wheel_pos = wheel_pos + 1'b1;
			used = slot_used[slot];
			if (used == 0) begin
				push_expected(KIND_EMPTY, '0, '0, 1'b0, 1'b0, 1'b1);
			end else begin
				for (i = 0; i < used; i++) begin
					c = slot_conns[slot][i];
					if (conn_refs[c] != 0)
						conn_refs[c] = conn_refs[c] - 1'b1;
					if (conn_refs[c] == 0)
						n_kills++;
					push_expected(KIND_EXPIRED, c, conn_refs[c], conn_refs[c] == 0, 1'b0,
						i + 1 == used);
				end
				slot_used[slot] = 0;
			end
		end
	endfunction

	// predicts at each accepted request, checks each accepted result
	initial begin
		result_t got;
		result_t want;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (cfg_we)
					expire_off = cfg_wdata;
				if (item_if.valid && item_if.ready)
					predict_request(item_if.op, item_if.conn_id, item_if.delay);
				if (result_if.valid && result_if.ready) begin
					got.kind      = kind_t'(result_if.kind);
					got.conn_id   = result_if.conn_id_out;
					got.remaining = result_if.remaining;
					got.killed    = result_if.killed;
					got.overflow  = result_if.overflow;
					got.last      = result_if.last;
					n_results++;
					if (expected_results.size() == 0) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORTS)
							$display("%0t: unexpected result kind %0d conn %0d rem %0d",
								$realtime, got.kind, got.conn_id, got.remaining);
					end else begin
						want = expected_results.pop_front();
						if (got !== want) begin
							fail_cnt++;
							if (fail_cnt <= MAX_REPORTS)
								$display("%0t: mismatch exp kind %0d conn %0d rem %0d ",
									$realtime, want.kind, want.conn_id, want.remaining,
									"kill %0b ovf %0b last %0b / ",
									want.killed, want.overflow, want.last,
									"got kind %0d conn %0d rem %0d ",
									got.kind, got.conn_id, got.remaining,
									"kill %0b ovf %0b last %0b",
									got.killed, got.overflow, got.last);
						end
					end
				end
			end
			result_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	task automatic send_request(logic op, logic [CONN_ID_W-1:0] conn,
			logic [DELAY_W-1:0] dly);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid   <= 1'b1;
		item_if.op      <= op;
		item_if.conn_id <= conn;
		item_if.delay   <= dly;
		do @(posedge clk); while (!item_if.ready);
	endtask

	task automatic wait_idle();
		item_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_expire_offset(logic [OFFSET_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic send_tick();
		send_request(OP_TICK, CONN_ID_W'($urandom), DELAY_W'($urandom));
	endtask

	// field extremes, repeated connections, empty slots and kills at reset offset
	task automatic test_field_extremes();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		send_request(OP_ADD, '0, '0);
		send_request(OP_ADD, '1, '1);
		send_request(OP_ADD, '1, '0);
		send_request(OP_ADD, '0, '1);
		send_request(OP_ADD, 10'h155, 4'h5);
		send_request(OP_ADD, 10'h2aa, 4'ha);
		repeat (WHEEL_SLOTS + 1) send_tick();
	endtask

	task automatic test_offset_extremes();
		set_expire_offset('0);
		// lands in the current slot, drained by the very next tick
		send_request(OP_ADD, 10'd5, '0);
		send_request(OP_ADD, 10'd6, '0);
		send_tick();
		set_expire_offset('1);
		send_request(OP_ADD, 10'd7, '1);
		send_request(OP_ADD, 10'd7, 4'd1);
		repeat (WHEEL_SLOTS) send_tick();
	endtask

	task automatic test_slot_overflow();
		logic [DELAY_W-1:0] dly;
		src_idle_pct  = 11;
		snk_stall_pct = 11;
		dly = DELAY_W'($urandom);
		// fill one slot past its depth, then drain the whole wheel
		repeat (SLOT_DEPTH + 2)
			send_request(OP_ADD, CONN_ID_W'($urandom_range(CONNS - 4, CONNS - 1)), dly);
		repeat (WHEEL_SLOTS) send_tick();
	endtask

	task automatic test_random_mix(int n, int src_pct, int snk_pct,
			logic [OFFSET_W-1:0] offset);
		logic [CONN_ID_W-1:0] conn;
		set_expire_offset(offset);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		repeat (n) begin
			// half the adds reuse a few connections so counts climb above one
			conn = $urandom_range(0, 1) ? CONN_ID_W'($urandom_range(0, 7))
				: CONN_ID_W'($urandom);
			if ($urandom_range(0, 99) < 40)
				send_tick();
			else
				send_request(OP_ADD, conn, DELAY_W'($urandom));
		end
	endtask

	initial begin
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		item_if.valid   <= 1'b0;
		item_if.op      <= OP_ADD;
		item_if.conn_id <= '0;
		item_if.delay   <= '0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		fail_cnt      = 0;
		n_adds        = 0;
		n_ticks       = 0;
		n_results     = 0;
		n_overflows   = 0;
		n_kills       = 0;
		wheel_pos     = '0;
		expire_off    = OFFSET_RESET;
		foreach (conn_refs[i])
			conn_refs[i] = '0;
		foreach (slot_used[i])
			slot_used[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_field_extremes();
		test_offset_extremes();
		test_slot_overflow();
		test_random_mix(50, 0, 0, '1);
		test_random_mix(50, 45, 0, '0);
		test_random_mix(50, 0, 45, OFFSET_W'($urandom));
		test_random_mix(50, 11, 11, OFFSET_W'($urandom));
		wait_idle();

		$display("run covered %0d adds (%0d refused on a full slot) and %0d ticks",
			n_adds, n_overflows, n_ticks);
		$display("%0d results checked, %0d connections expired to zero, %0d failures",
			n_results, n_kills, fail_cnt);
		if (expected_results.size() != 0)
			$display("%0d expected results never arrived", expected_results.size());
		if (fail_cnt == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
